// ===== src/ihm_pkg.sv =====
// Shared types and constants of the icon outline halo mask block.
package ihm_pkg;

	localparam int unsigned APB_ADDR_W = 2;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned ARGB_W     = 32;
	localparam int unsigned ALPHA_W    = 8;
	localparam int unsigned RGB_W      = 24;
	localparam int unsigned TAP_N      = 9;

	// Window taps are numbered 3*row_offset + column_offset.
	localparam int unsigned TAP_CENTRE = 4;
	localparam int unsigned TAP_UP     = 3;

	localparam logic [APB_ADDR_W-1:0] REG_HALO_ALPHA   = '0;
	localparam logic [ALPHA_W-1:0]    HALO_ALPHA_RESET = 8'd220;
	localparam logic [RGB_W-1:0]      WHITE_RGB        = 24'hFF_FFFF;

	typedef logic [ARGB_W-1:0] argb_t;

	typedef enum logic [1:0] {
		PH_MAIN,
		PH_EDGE,
		PH_BORDER
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic   col_ge1;
		logic   col_ge2;
		logic   row_ge1;
		logic   row_ge2;
	} win_ctl_t;

endpackage

// ===== src/ihm_if.sv =====
// Valid/ready stream interfaces for input pixels and output pixels.
interface ihm_pix_if;
	import ihm_pkg::*;

	logic  valid;
	logic  ready;
	argb_t pixel_argb;

	modport source (output valid, output pixel_argb, input ready);
	modport sink (input valid, input pixel_argb, output ready);
endinterface

interface ihm_res_if;
	import ihm_pkg::*;

	logic  valid;
	logic  ready;
	argb_t out_argb;
	logic  end_of_run;
	logic  end_of_icon;

	modport source (output valid, output out_argb, output end_of_run, output end_of_icon,
		input ready);
	modport sink (input valid, input out_argb, input end_of_run, input end_of_icon,
		output ready);
endinterface

// ===== src/ihm_cell.sv =====
// One delay cell of a line store chain: loads its neighbour's value on every shift.
module ihm_cell #(
	parameter int unsigned W = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         shift,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;
endmodule

// ===== src/ihm_window.sv =====
// Output pixel builder: masks the 3x3 opacity window and picks copy, halo or clear.
module ihm_window (
	input  ihm_pkg::win_ctl_t            ctl,
	input  logic [ihm_pkg::TAP_N-1:0]    taps,
	input  ihm_pkg::argb_t               src_main,
	input  ihm_pkg::argb_t               src_edge,
	input  logic [ihm_pkg::ALPHA_W-1:0]  halo_alpha,
	output ihm_pkg::argb_t               out_argb
);
	import ihm_pkg::*;

	logic [2:0] col_ok;
	logic [2:0] row_ok;
	logic       halo;
	logic       src_opaque;
	argb_t      src_color;

	always_comb begin
		row_ok     = {ctl.row_ge2, ctl.row_ge1, 1'b1};
		col_ok     = '0;
		src_opaque = 1'b0;
		src_color  = src_main;
		unique case (ctl.phase)
			PH_MAIN: begin
				col_ok     = {ctl.col_ge2, ctl.col_ge1, 1'b1};
				src_opaque = ctl.col_ge1 & ctl.row_ge1 & taps[TAP_CENTRE];
				src_color  = src_main;
			end
			PH_EDGE: begin
				col_ok     = 3'b011;
				src_opaque = ctl.row_ge1 & taps[TAP_UP];
				src_color  = src_edge;
			end
			PH_BORDER: begin
				col_ok = 3'b001;
			end
			default: begin
				col_ok = '0;
			end
		endcase

		halo = 1'b0;
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				halo = halo | (taps[3*j+i] & row_ok[j] & col_ok[i]);
			end
		end

		if (src_opaque) begin
			out_argb = src_color;
		end else begin
			out_argb = {(halo ? halo_alpha : {ALPHA_W{1'b0}}), WHITE_RGB};
		end
	end
endmodule

// ===== src/icon_outline_halo_mask_top.sv =====
// Top level of the icon outline halo mask: line store chains, sequencer and APB register.
//
// Pixels of a square ICON_SIZE x ICON_SIZE icon enter on the pix channel in raster
// order, one beat per pixel, and an (ICON_SIZE+2) x (ICON_SIZE+2) outlined icon
// leaves on the res channel, also in raster order. end_of_run marks the last output
// beat caused by an input beat; end_of_icon marks the final output pixel.
// The APB register at byte address 0 holds the halo alpha (reset value 220);
// write it only while the block is idle.
// Without a stall the first output beat of a pixel is registered in the pending
// register and then in the output register, from which it is valid on res.
// The block takes one pixel per cycle while the receiver does not stall. The last
// pixel of each row holds the input while the two right border pixels go out, and
// the last pixel of the icon holds it while the bottom border rows are emitted.
// The output register sends one pixel per cycle when not stalled; the cell chains
// shift once per input pixel or bottom border pixel, not for right border pixels.
// After reset all opacity cells are clear and the next pixel is taken as (0, 0).
// When the receiver stalls, the output register holds its beat, the pending
// pixel waits behind it and pix.ready drops; nothing is lost or repeated.
module icon_outline_halo_mask_top #(
	parameter int unsigned ICON_SIZE = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ihm_pix_if.sink                           pix,
	ihm_res_if.source                         res,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ihm_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [ihm_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [ihm_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import ihm_pkg::*;

	localparam int unsigned CW        = $clog2(ICON_SIZE + 2);
	localparam int unsigned OPQ_DEPTH = 2 * ICON_SIZE + 3;
	localparam int unsigned COL_DEPTH = ICON_SIZE + 2;
	localparam logic [CW-1:0] LAST_COL   = CW'(ICON_SIZE - 1);
	localparam logic [CW-1:0] LAST_ROW   = CW'(ICON_SIZE - 1);
	localparam logic [CW-1:0] FIRST_VIRT = CW'(ICON_SIZE);
	localparam logic [CW-1:0] LAST_VIRT  = CW'(ICON_SIZE + 1);
	localparam logic [CW-1:0] ONE        = CW'(1);

	logic [ALPHA_W-1:0] halo_alpha_q;
	logic               cfg_wr;

	logic [CW-1:0] fc_q;
	logic [CW-1:0] fr_q;
	logic          feed_virt;

	logic          pend_valid_q;
	logic [CW-1:0] pc_q;
	logic [CW-1:0] pr_q;
	phase_t        phase_q;

	logic          res_valid_q;
	argb_t         res_argb_q;
	logic          res_eor_q;
	logic          res_eoi_q;

	logic          out_free;
	logic          emit;
	logic          row_end;
	logic          last_phase;
	logic          advance_ok;
	logic          advance;
	logic          new_opq;
	logic          eor;
	logic          eoi;

	logic [OPQ_DEPTH-1:0] opq;
	argb_t                col [COL_DEPTH];
	logic [TAP_N-1:0]     taps;
	win_ctl_t             ctl;
	argb_t                win_argb;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr == REG_HALO_ALPHA);
	assign prdata = (paddr == REG_HALO_ALPHA) ?
		{{(APB_DATA_W - ALPHA_W){1'b0}}, halo_alpha_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halo_alpha_q <= HALO_ALPHA_RESET;
		end else if (cfg_wr) begin
			halo_alpha_q <= pwdata[ALPHA_W-1:0];
		end
	end

	// Sequencing. Rows past the icon are fed as transparent pixels to flush the border.
	assign out_free   = !res_valid_q || res.ready;
	assign emit       = pend_valid_q && out_free;
	assign row_end    = (pc_q == LAST_COL);
	assign last_phase = ((phase_q == PH_MAIN) && !row_end) || (phase_q == PH_BORDER);
	assign advance_ok = !pend_valid_q || (emit && last_phase);
	assign feed_virt  = (fr_q >= FIRST_VIRT);
	assign pix.ready  = advance_ok && !feed_virt;
	assign advance    = advance_ok && (feed_virt || pix.valid);
	assign new_opq    = !feed_virt && (pix.pixel_argb[ARGB_W-1 -: ALPHA_W] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= '0;
			fr_q <= '0;
		end else if (advance) begin
			if (fc_q == LAST_COL) begin
				fc_q <= '0;
				fr_q <= (fr_q == LAST_VIRT) ? '0 : fr_q + ONE;
			end else begin
				fc_q <= fc_q + ONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pc_q         <= '0;
			pr_q         <= '0;
			phase_q      <= PH_MAIN;
		end else if (advance) begin
			pend_valid_q <= 1'b1;
			pc_q         <= fc_q;
			pr_q         <= fr_q;
			phase_q      <= PH_MAIN;
		end else if (emit && last_phase) begin
			pend_valid_q <= 1'b0;
		end else if (emit) begin
			phase_q <= (phase_q == PH_MAIN) ? PH_EDGE : PH_BORDER;
		end
	end

	// Cell chains.
	for (genvar g = 0; g < OPQ_DEPTH; g++) begin : g_opq
		if (g == 0) begin : g_head
			ihm_cell #(.W(1)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (advance),
				.d      (new_opq),
				.q      (opq[g])
			);
		end else begin : g_body
			ihm_cell #(.W(1)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (advance),
				.d      (opq[g-1]),
				.q      (opq[g])
			);
		end
	end

	for (genvar g = 0; g < COL_DEPTH; g++) begin : g_col
		if (g == 0) begin : g_head
			ihm_cell #(.W(ARGB_W)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (advance),
				.d      (pix.pixel_argb),
				.q      (col[g])
			);
		end else begin : g_body
			ihm_cell #(.W(ARGB_W)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (advance),
				.d      (col[g-1]),
				.q      (col[g])
			);
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_tap_row
		for (genvar i = 0; i < 3; i++) begin : g_tap_col
			assign taps[3*j+i] = opq[j*ICON_SIZE+i];
		end
	end

	assign ctl.phase   = phase_q;
	assign ctl.col_ge1 = (pc_q >= ONE);
	assign ctl.col_ge2 = (pc_q > ONE);
	assign ctl.row_ge1 = (pr_q >= ONE);
	assign ctl.row_ge2 = (pr_q > ONE);

	ihm_window u_window (
		.ctl        (ctl),
		.taps       (taps),
		.src_main   (col[ICON_SIZE+1]),
		.src_edge   (col[ICON_SIZE]),
		.halo_alpha (halo_alpha_q),
		.out_argb   (win_argb)
	);

	assign eor = last_phase && ((pr_q < FIRST_VIRT) ? !(row_end && (pr_q == LAST_ROW))
		: (row_end && (pr_q == LAST_VIRT)));
	assign eoi = (phase_q == PH_BORDER) && (pr_q == LAST_VIRT);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= pend_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_argb_q <= win_argb;
			res_eor_q  <= eor;
			res_eoi_q  <= eoi;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.out_argb    = res_argb_q;
	assign res.end_of_run  = res_eor_q;
	assign res.end_of_icon = res_eoi_q;
endmodule

// ===== src/ihm_checker.sv =====
// Port checker for the icon outline halo mask top level, with its bind statement.
module ihm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           pix_valid,
	input logic           pix_ready,
	input logic           res_valid,
	input logic           res_ready,
	input ihm_pkg::argb_t out_argb,
	input logic           end_of_run,
	input logic           end_of_icon
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_argb) && $stable(end_of_run)
			&& $stable(end_of_icon))
		else $error("Stalled output beat changed or vanished.");

	a_icon_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && end_of_icon |-> end_of_run)
		else $error("Last pixel of the icon is not flagged as the end of a run.");

	a_in_gives_out: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |-> ##2 res_valid)
		else $error("Accepted input beat produced no output beat in time.");
endmodule

bind icon_outline_halo_mask_top ihm_checker u_ihm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pix_valid   (pix.valid),
	.pix_ready   (pix.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.out_argb    (res.out_argb),
	.end_of_run  (res.end_of_run),
	.end_of_icon (res.end_of_icon)
);
